/* rtl/core/rgb_to_hsl_convert_defines.svh */
// Assertion macros for the RGB to HSL converter.
`ifndef RGB_TO_HSL_CONVERT_DEFINES_SVH
`define RGB_TO_HSL_CONVERT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RHC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define RHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/rhc_pkg.sv */
// Shared widths, latency and pipeline stage type of the RGB to HSL converter.
package rhc_pkg;

   localparam int RGB_W     = 8;
   localparam int OUT_W     = 16;
   localparam int QUO_W     = OUT_W + 1;
   localparam int SAT_DEN_W = 9;
   localparam int HUE_DEN_W = 12;
   localparam int FRONT_LAT = 2;
   localparam int PIPE_LAT  = FRONT_LAT + QUO_W;

   typedef struct packed {
      logic                 valid;
      logic [OUT_W-1:0]     lum;
      logic [SAT_DEN_W-1:0] sat_rem;
      logic [SAT_DEN_W-1:0] sat_den;
      logic [QUO_W-1:0]     sat_work;
      logic [HUE_DEN_W-1:0] hue_rem;
      logic [HUE_DEN_W-1:0] hue_den;
      logic [QUO_W-1:0]     hue_work;
   } div_stage_type;

endpackage

/* rtl/core/rhc_front.sv */
// Front end: channel max/min, hue numerator, lightness and divider operands.
module rhc_front import rhc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic [RGB_W-1:0]     red,
   input  logic [RGB_W-1:0]     green,
   input  logic [RGB_W-1:0]     blue,
   output div_stage_type        out_stage
);

   localparam logic [1:0] SEL_RED   = 2'd0;
   localparam logic [1:0] SEL_GREEN = 2'd1;
   localparam logic [1:0] SEL_BLUE  = 2'd2;

   logic              valid_a_ff;
   logic [1:0]        sel_a_ff, sel_a_in;
   logic [7:0]        d_a_ff, d_a_in;
   logic [8:0]        s_a_ff, s_a_in;
   logic signed [8:0] diff_a_ff, diff_a_in;
   logic [7:0]        mx, mn;

   always_comb begin
      mx = red;
      mn = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      d_a_in = mx - mn;
      s_a_in = {1'b0, mx} + {1'b0, mn};
      if (red == mx) begin
         sel_a_in  = SEL_RED;
         diff_a_in = $signed({1'b0, green} - {1'b0, blue});
      end else if (green == mx) begin
         sel_a_in  = SEL_GREEN;
         diff_a_in = $signed({1'b0, blue} - {1'b0, red});
      end else begin
         sel_a_in  = SEL_BLUE;
         diff_a_in = $signed({1'b0, red} - {1'b0, green});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      sel_a_ff  <= sel_a_in;
      d_a_ff    <= d_a_in;
      s_a_ff    <= s_a_in;
      diff_a_ff <= diff_a_in;
   end

   logic [10:0]        six;
   logic [10:0]        base;
   logic signed [12:0] hue_sum;
   logic signed [12:0] hue_fix;
   logic [8:0]         s_comp;
   logic [7:0]         den;
   logic [24:0]        sat_num;
   logic [16:0]        lum_wide;
   div_stage_type      out_ff, out_in;

   always_comb begin
      six = {1'b0, d_a_ff, 2'b00} + {2'b00, d_a_ff, 1'b0};
      unique case (sel_a_ff)
         SEL_RED:   base = 11'd0;
         SEL_GREEN: base = {2'b00, d_a_ff, 1'b0};
         SEL_BLUE:  base = {1'b0, d_a_ff, 2'b00};
         default:   base = 11'd0;
      endcase
      hue_sum = $signed({2'b00, base}) + $signed({{4{diff_a_ff[8]}}, diff_a_ff});
      hue_fix = hue_sum[12] ? (hue_sum + $signed({2'b00, six})) : hue_sum;

      s_comp  = 9'd510 - s_a_ff;
      den     = (s_a_ff < 9'd255) ? s_a_ff[7:0] : s_comp[7:0];
      sat_num = {d_a_ff, 17'd0} - {16'd0, d_a_ff, 1'b0} + {17'd0, den};

      lum_wide = {s_a_ff, 8'd0} + {8'd0, s_a_ff} + 17'd1;

      out_in.valid = valid_a_ff;
      out_in.lum   = lum_wide[16:1];
      if (d_a_ff == 8'd0) begin
         out_in.sat_rem  = '0;
         out_in.sat_den  = SAT_DEN_W'(1);
         out_in.sat_work = '0;
         out_in.hue_rem  = '0;
         out_in.hue_den  = HUE_DEN_W'(1);
         out_in.hue_work = '0;
      end else begin
         out_in.sat_rem  = {1'b0, sat_num[24:17]};
         out_in.sat_den  = {den, 1'b0};
         out_in.sat_work = sat_num[16:0];
         out_in.hue_rem  = {1'b0, hue_fix[10:0]};
         out_in.hue_den  = {six, 1'b0};
         out_in.hue_work = {6'd0, six};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.lum      <= out_in.lum;
      out_ff.sat_rem  <= out_in.sat_rem;
      out_ff.sat_den  <= out_in.sat_den;
      out_ff.sat_work <= out_in.sat_work;
      out_ff.hue_rem  <= out_in.hue_rem;
      out_ff.hue_den  <= out_in.hue_den;
      out_ff.hue_work <= out_in.hue_work;
   end

   assign out_stage = out_ff;

endmodule

/* rtl/core/rhc_div_step.sv */
// One restoring division step for the saturation and hue lanes.
module rhc_div_step import rhc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  div_stage_type in_stage,
   output div_stage_type out_stage
);

   logic [SAT_DEN_W:0] sat_trial, sat_diff;
   logic               sat_ge;
   logic [HUE_DEN_W:0] hue_trial, hue_diff;
   logic               hue_ge;
   div_stage_type      out_ff, out_in;

   always_comb begin
      sat_trial = {in_stage.sat_rem, in_stage.sat_work[QUO_W-1]};
      sat_ge    = sat_trial >= {1'b0, in_stage.sat_den};
      sat_diff  = sat_trial - {1'b0, in_stage.sat_den};
      hue_trial = {in_stage.hue_rem, in_stage.hue_work[QUO_W-1]};
      hue_ge    = hue_trial >= {1'b0, in_stage.hue_den};
      hue_diff  = hue_trial - {1'b0, in_stage.hue_den};

      out_in.valid    = in_stage.valid;
      out_in.lum      = in_stage.lum;
      out_in.sat_den  = in_stage.sat_den;
      out_in.sat_rem  = sat_ge ? sat_diff[SAT_DEN_W-1:0] : sat_trial[SAT_DEN_W-1:0];
      out_in.sat_work = {in_stage.sat_work[QUO_W-2:0], sat_ge};
      out_in.hue_den  = in_stage.hue_den;
      out_in.hue_rem  = hue_ge ? hue_diff[HUE_DEN_W-1:0] : hue_trial[HUE_DEN_W-1:0];
      out_in.hue_work = {in_stage.hue_work[QUO_W-2:0], hue_ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= out_in.valid;
      end
      out_ff.lum      <= out_in.lum;
      out_ff.sat_rem  <= out_in.sat_rem;
      out_ff.sat_den  <= out_in.sat_den;
      out_ff.sat_work <= out_in.sat_work;
      out_ff.hue_rem  <= out_in.hue_rem;
      out_ff.hue_den  <= out_in.hue_den;
      out_ff.hue_work <= out_in.hue_work;
   end

   assign out_stage = out_ff;

endmodule

/* rtl/core/rgb_to_hsl_convert.sv */
// Top level of the pipelined RGB to HSL converter.
//
//   channel   ports                                                    handshake
//   request   req_red, req_green, req_blue                             start high, busy low
//   response  rsp_hue_angle, rsp_saturation_level, rsp_lightness_level rsp_strobe, one cycle
//
// One item enters per cycle; each result passes through two front-end
// stages, then one stage per quotient bit of the 17-bit restoring dividers
// that run the saturation and hue lanes side by side.
// Reset clears the valid bits of every stage; payload registers are not reset.
// busy stays low: the receiver cannot stall, so nothing ever holds the pipeline.
`include "rgb_to_hsl_convert_defines.svh"

module rgb_to_hsl_convert import rhc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [RGB_W-1:0] req_red,
   input  logic [RGB_W-1:0] req_green,
   input  logic [RGB_W-1:0] req_blue,
   output logic             rsp_strobe,
   output logic [OUT_W-1:0] rsp_hue_angle,
   output logic [OUT_W-1:0] rsp_saturation_level,
   output logic [OUT_W-1:0] rsp_lightness_level
);

   logic          req_accept;
   logic          req_grey;
   div_stage_type chain [0:QUO_W];

   assign busy       = 1'b0;
   assign req_accept = start && !busy;
   assign req_grey   = req_accept && (req_red == req_green) && (req_green == req_blue);

   rhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .out_stage (chain[0])
   );

   for (genvar i = 0; i < QUO_W; i++) begin : g_div
      rhc_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_stage  (chain[i]),
         .out_stage (chain[i+1])
      );
   end

   assign rsp_strobe           = chain[QUO_W].valid;
   assign rsp_hue_angle        = chain[QUO_W].hue_work[OUT_W-1:0];
   assign rsp_saturation_level = chain[QUO_W].sat_work[OUT_W-1:0];
   assign rsp_lightness_level  = chain[QUO_W].lum;

   `RHC_ASSERT_SAME(a_strobe_has_item, clock, reset, rsp_strobe,
      $past(req_accept, PIPE_LAT), "result without an accepted item")
   `RHC_ASSERT_SAME(a_grey_zero, clock, reset, rsp_strobe && $past(req_grey, PIPE_LAT),
      (rsp_hue_angle == '0) && (rsp_saturation_level == '0),
      "grey pixel gave nonzero hue or saturation")
   `RHC_ASSERT_SAME(a_sat_fits, clock, reset, rsp_strobe,
      !chain[QUO_W].sat_work[QUO_W-1], "saturation quotient overflowed")

endmodule

/* tb/tb.sv */
// Self-checking testbench for the RGB to HSL pixel converter.
`timescale 1ns / 100ps

module tb import rhc_pkg::*; ();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = PIPE_LAT + 8;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [OUT_W-1:0] hue;
      logic [OUT_W-1:0] sat;
      logic [OUT_W-1:0] lum;
   } hsl_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic [RGB_W-1:0] req_red   = '0;
   logic [RGB_W-1:0] req_green = '0;
   logic [RGB_W-1:0] req_blue  = '0;
   logic             rsp_strobe;
   logic [OUT_W-1:0] rsp_hue_angle;
   logic [OUT_W-1:0] rsp_saturation_level;
   logic [OUT_W-1:0] rsp_lightness_level;

   hsl_type     hsl_pending[$];
   int unsigned mismatches = 0;
   int unsigned cycles     = 0;
   int unsigned idle_pct   = 0;

   rgb_to_hsl_convert i_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_red              (req_red),
      .req_green            (req_green),
      .req_blue             (req_blue),
      .rsp_strobe           (rsp_strobe),
      .rsp_hue_angle        (rsp_hue_angle),
      .rsp_saturation_level (rsp_saturation_level),
      .rsp_lightness_level  (rsp_lightness_level)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
      return (2 * num + den) / (2 * den);
   endfunction

   function automatic hsl_type compute_hsl(logic [RGB_W-1:0] r, logic [RGB_W-1:0] g,
                                           logic [RGB_W-1:0] b);
      longint unsigned mx, mn, d, s, den, six, num, quo;
      hsl_type         res;
      mx = r;
      mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      s = mx + mn;
      quo = round_div(s * 65535, 510);
      res.lum = quo[OUT_W-1:0];
      res.hue = '0;
      res.sat = '0;
      if (d != 0) begin
         den = (s < 255) ? s : 510 - s;
         six = 6 * d;
         quo = round_div(d * 65535, den);
         res.sat = quo[OUT_W-1:0];
         if (r == mx) begin
            num = six + g - b;
         end else if (g == mx) begin
            num = six + 2 * d + b - r;
         end else begin
            num = six + 4 * d + r - g;
         end
         if (num >= six) num -= six;
         quo = round_div(num * 65536, six);
         res.hue = quo[OUT_W-1:0];
      end
      return res;
   endfunction

   task automatic send_pixel(input logic [RGB_W-1:0] r, input logic [RGB_W-1:0] g,
                             input logic [RGB_W-1:0] b);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start     <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      do @(posedge clock); while (busy);
   endtask

   task automatic send_random_pixels(input int unsigned count);
      logic [RGB_W-1:0] r, g, b;
      for (int unsigned n = 0; n < count; n++) begin
         r = RGB_W'($urandom_range(255));
         g = RGB_W'($urandom_range(255));
         b = RGB_W'($urandom_range(255));
         case ($urandom_range(9))
            0: begin
               g = r;
               b = r;
            end
            1: g = r;
            2: b = g;
            3: r = b;
            4: begin
               r = $urandom_range(1) ? 8'hff : 8'h00;
               b = $urandom_range(1) ? 8'hff : b;
            end
            default: ;
         endcase
         send_pixel(r, g, b);
      end
   endtask

   task automatic test_corner_pixels();
      idle_pct = 0;
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hff, 8'hff, 8'hff);
      send_pixel(8'h80, 8'h80, 8'h80);
      send_pixel(8'hff, 8'h00, 8'h00);
      send_pixel(8'h00, 8'hff, 8'h00);
      send_pixel(8'h00, 8'h00, 8'hff);
      send_pixel(8'hff, 8'hff, 8'h00);
      send_pixel(8'h00, 8'hff, 8'hff);
      send_pixel(8'hff, 8'h00, 8'hff);
      send_pixel(8'hff, 8'h00, 8'h01);
      send_pixel(8'h01, 8'h00, 8'h00);
      send_pixel(8'h00, 8'h01, 8'h01);
      send_pixel(8'hfe, 8'hff, 8'hfe);
      send_pixel(8'hff, 8'hfe, 8'hfe);
      send_pixel(8'h7f, 8'h80, 8'h7f);
      send_pixel(8'h80, 8'h7e, 8'h7f);
      send_pixel(8'h80, 8'h7f, 8'h7f);
      send_pixel(8'hc8, 8'h37, 8'h64);
      send_pixel(8'h55, 8'haa, 8'h55);
      send_pixel(8'h0f, 8'hf0, 8'h33);
      send_pixel(8'h01, 8'h02, 8'h03);
      send_pixel(8'hfd, 8'hfc, 8'hfe);
   endtask

   task automatic test_streaming_pixels();
      idle_pct = 0;
      send_random_pixels(250);
   endtask

   task automatic test_sparse_pixels();
      idle_pct = 83;
      send_random_pixels(250);
   endtask

   task automatic test_mixed_gaps();
      idle_pct = 16;
      send_random_pixels(250);
   endtask

   always @(posedge clock) begin
      hsl_type want;
      if (!reset) begin
         if (start && !busy) begin
            hsl_pending.push_back(compute_hsl(req_red, req_green, req_blue));
         end
         if (rsp_strobe === 1'b1) begin
            if (hsl_pending.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("%0t: unexpected result hue=%h sat=%h lum=%h", $realtime,
                           rsp_hue_angle, rsp_saturation_level, rsp_lightness_level);
               end
            end else begin
               want = hsl_pending.pop_front();
               if (rsp_hue_angle !== want.hue || rsp_saturation_level !== want.sat ||
                   rsp_lightness_level !== want.lum) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX) begin
                     $display("%0t: expected hue=%h sat=%h lum=%h, got hue=%h sat=%h lum=%h",
                              $realtime, want.hue, want.sat, want.lum, rsp_hue_angle,
                              rsp_saturation_level, rsp_lightness_level);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_pixels();
      test_streaming_pixels();
      test_sparse_pixels();
      test_mixed_gaps();
      start <= 1'b0;
      while (hsl_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && hsl_pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
